[hdl/rtp_pkg.sv]
// ----------------------------------------------------------------------------
// rtp_pkg
// Shared constants for the row tensor product block: register indexes,
// register widths, reset values, data format widths and parameter defaults.
// ----------------------------------------------------------------------------
package rtp_pkg;

    // parameter defaults
    localparam int DEF_MAX_MATRICES = 3;
    localparam int DEF_MAX_COLS     = 4;

    // data format
    localparam int DATA_W = 32;
    localparam int FRAC_W = 16;
    localparam int PROD_W = 2 * DATA_W;

    // configuration register map
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 3;
    localparam int MCOUNT_W   = 2;
    localparam int COLS_W     = 3;
    localparam int NUM_COL_REGS = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_FIRST   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_SECOND  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_THIRD   = 2'd3;

    localparam logic [MCOUNT_W-1:0] MCOUNT_RESET = 2'd1;
    localparam logic [COLS_W-1:0]   COLS_RESET   = 3'd1;

endpackage

[hdl/rtp_store.sv]
// ----------------------------------------------------------------------------
// rtp_store
// Row store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rtp_store #(
    parameter int DEPTH = rtp_pkg::DEF_MAX_MATRICES * rtp_pkg::DEF_MAX_COLS,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [AW-1:0]               wr_addr,
    input  logic [rtp_pkg::DATA_W-1:0]  wr_data,
    input  logic                        rd_en,
    input  logic [AW-1:0]               rd_addr,
    output logic [rtp_pkg::DATA_W-1:0]  rd_data
);

    logic [rtp_pkg::DATA_W-1:0] mem [DEPTH];
    logic [rtp_pkg::DATA_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/rtp_mul.sv]
// ----------------------------------------------------------------------------
// rtp_mul
// Shared Q16.16 multiply unit: registered full product, then an arithmetic
// shift by the fraction width and saturation to the data width.
// ----------------------------------------------------------------------------
module rtp_mul (
    input  logic                               clk,
    input  logic                               load,
    input  logic signed [rtp_pkg::DATA_W-1:0]  a,
    input  logic signed [rtp_pkg::DATA_W-1:0]  b,
    output logic signed [rtp_pkg::DATA_W-1:0]  q,
    output logic                               sat
);

    localparam int SH_W = rtp_pkg::PROD_W - rtp_pkg::FRAC_W;

    logic signed [rtp_pkg::PROD_W-1:0] prod_reg;
    logic signed [SH_W-1:0]            shifted;
    logic                              fits;

    // full product register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= a * b;
        end
    end

    // floor shift, then clamp to the signed range
    always_comb
    begin
        shifted = prod_reg[rtp_pkg::PROD_W-1:rtp_pkg::FRAC_W];
        fits = (shifted[SH_W-1:rtp_pkg::DATA_W-1] == '0) ||
               (shifted[SH_W-1:rtp_pkg::DATA_W-1] == '1);
        sat = !fits;
        if (fits)
        begin
            q = shifted[rtp_pkg::DATA_W-1:0];
        end
        else if (shifted[SH_W-1])
        begin
            q = {1'b1, {(rtp_pkg::DATA_W-1){1'b0}}};
        end
        else
        begin
            q = {1'b0, {(rtp_pkg::DATA_W-1){1'b1}}};
        end
    end

endmodule

[hdl/row_tensor_product.sv]
// ----------------------------------------------------------------------------
// row_tensor_product
// Row-wise tensor product of up to three matrices in signed Q16.16.
// ----------------------------------------------------------------------------
// Elements of one row are taken one per cycle while in_stall is low (all
// columns of matrix 0, then matrix 1, then matrix 2) and held in the row
// store. The element that completes the row starts the product pass, during
// which in_stall is high. Products leave in Kronecker order, last matrix's
// column fastest, each one built from the last factor toward the first with
// one shared multiplier: one store read and capture per factor, one
// saturation step per multiply and one output transfer step, during which
// out_stall can hold it. A row of m matrices with c0..c2 columns takes
// c0+..+c(m-1) elements and gives c0*..*c(m-1) products, paced by the single
// store read port and the multiplier. Configuration must be written only
// while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module row_tensor_product #(
    parameter int MAX_MATRICES = rtp_pkg::DEF_MAX_MATRICES,
    parameter int MAX_COLS     = rtp_pkg::DEF_MAX_COLS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_write,
    input  logic [rtp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rtp_pkg::CFG_DATA_W-1:0]      cfg_data,
    // input channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [rtp_pkg::DATA_W-1:0]   value,
    input  logic                                final_row,
    // output channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [rtp_pkg::DATA_W-1:0]   product,
    output logic                                row_done,
    output logic                                matrix_done,
    output logic                                saturated
);

    localparam int STORE_DEPTH = MAX_MATRICES * MAX_COLS;
    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int TW = $clog2(STORE_DEPTH + 1);
    localparam int MW = $clog2(MAX_MATRICES + 1);
    localparam int JW = (MAX_MATRICES > 1) ? $clog2(MAX_MATRICES) : 1;
    localparam int CW = $clog2(MAX_COLS + 1);
    localparam int DW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_CAPT = 3'd2;
    localparam logic [2:0] S_SAT  = 3'd3;
    localparam logic [2:0] S_WAIT = 3'd4;

    // configuration registers
    logic [rtp_pkg::MCOUNT_W-1:0] mcount_reg;
    logic [rtp_pkg::COLS_W-1:0]   cols_cfg_reg [rtp_pkg::NUM_COL_REGS];

    // effective geometry
    logic [MW-1:0] m_eff;
    logic [CW-1:0] cols_eff [MAX_MATRICES];
    logic [TW-1:0] base_eff [MAX_MATRICES];
    logic [TW-1:0] total_eff;

    // sequencer state
    logic [2:0]    state_reg, state_next;
    logic [TW-1:0] count_reg, count_next;
    logic [JW-1:0] j_reg, j_next;
    logic [DW-1:0] digit_reg [MAX_MATRICES];
    logic [DW-1:0] digit_next [MAX_MATRICES];
    logic          last_row_reg, last_row_next;
    logic          out_valid_reg, out_valid_next;

    // payload state
    logic signed [rtp_pkg::DATA_W-1:0] acc_reg, acc_next;
    logic                              sat_reg, sat_next;
    logic signed [rtp_pkg::DATA_W-1:0] product_reg, product_next;
    logic                              row_done_reg, row_done_next;
    logic                              matrix_done_reg, matrix_done_next;
    logic                              saturated_reg, saturated_next;

    // datapath links
    logic                              in_xfer;
    logic                              st_wr_en;
    logic                              st_rd_en;
    logic [AW-1:0]                     st_rd_addr;
    logic [TW-1:0]                     rd_sum;
    logic [rtp_pkg::DATA_W-1:0]        st_rd_data;
    logic                              mul_load;
    logic signed [rtp_pkg::DATA_W-1:0] mul_q;
    logic                              mul_sat;
    logic [DW-1:0]                     digit_adv [MAX_MATRICES];
    logic                              last_prod;
    logic                              emit;
    logic signed [rtp_pkg::DATA_W-1:0] emit_val;
    logic                              emit_sat;
    logic [TW-1:0]                     count_inc;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mcount_reg <= rtp_pkg::MCOUNT_RESET;
            for (int i = 0; i < rtp_pkg::NUM_COL_REGS; i++)
            begin
                cols_cfg_reg[i] <= rtp_pkg::COLS_RESET;
            end
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                rtp_pkg::CFG_MATRIX_COUNT:
                    mcount_reg <= cfg_data[rtp_pkg::MCOUNT_W-1:0];
                rtp_pkg::CFG_COLS_FIRST:  cols_cfg_reg[0] <= cfg_data;
                rtp_pkg::CFG_COLS_SECOND: cols_cfg_reg[1] <= cfg_data;
                rtp_pkg::CFG_COLS_THIRD:  cols_cfg_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // clamp registers to the supported range and lay out the store
    always_comb
    begin
        logic [TW-1:0] run;
        run = '0;
        if (mcount_reg == '0)
        begin
            m_eff = MW'(1);
        end
        else if (int'(mcount_reg) > MAX_MATRICES)
        begin
            m_eff = MW'(MAX_MATRICES);
        end
        else
        begin
            m_eff = MW'(mcount_reg);
        end
        for (int j = 0; j < MAX_MATRICES; j++)
        begin
            if (cols_cfg_reg[j] == '0)
            begin
                cols_eff[j] = CW'(1);
            end
            else if (int'(cols_cfg_reg[j]) > MAX_COLS)
            begin
                cols_eff[j] = CW'(MAX_COLS);
            end
            else
            begin
                cols_eff[j] = CW'(cols_cfg_reg[j]);
            end
            base_eff[j] = run;
            if (j < int'(m_eff))
            begin
                run = run + TW'(cols_eff[j]);
            end
        end
        total_eff = run;
    end

    // kronecker counter step, last matrix fastest
    always_comb
    begin
        logic carry;
        carry = 1'b1;
        for (int j = MAX_MATRICES - 1; j >= 0; j--)
        begin
            digit_adv[j] = digit_reg[j];
            if (j < int'(m_eff) && carry)
            begin
                if ((CW'(digit_reg[j]) + CW'(1)) < cols_eff[j])
                begin
                    digit_adv[j] = digit_reg[j] + DW'(1);
                    carry = 1'b0;
                end
                else
                begin
                    digit_adv[j] = '0;
                end
            end
        end
        last_prod = carry;
    end

    assign in_stall = (state_reg != S_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign st_wr_en = in_xfer && (count_reg < TW'(STORE_DEPTH));
    assign rd_sum     = base_eff[j_reg] + TW'(digit_reg[j_reg]);
    assign st_rd_addr = rd_sum[AW-1:0];
    assign st_rd_en   = (state_reg == S_READ);
    assign count_inc  = count_reg + TW'(1);

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        j_next           = j_reg;
        digit_next       = digit_reg;
        last_row_next    = last_row_reg;
        out_valid_next   = out_valid_reg;
        acc_next         = acc_reg;
        sat_next         = sat_reg;
        product_next     = product_reg;
        row_done_next    = row_done_reg;
        matrix_done_next = matrix_done_reg;
        saturated_next   = saturated_reg;
        mul_load         = 1'b0;
        emit             = 1'b0;
        emit_val         = acc_reg;
        emit_sat         = sat_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    if (count_inc >= total_eff)
                    begin
                        count_next    = '0;
                        last_row_next = final_row;
                        j_next        = JW'(m_eff - MW'(1));
                        for (int j = 0; j < MAX_MATRICES; j++)
                        begin
                            digit_next[j] = '0;
                        end
                        state_next = S_READ;
                    end
                    else
                    begin
                        count_next = count_inc;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_CAPT;
            end
            S_CAPT:
            begin
                if (j_reg == JW'(m_eff - MW'(1)))
                begin
                    // innermost factor starts the product
                    acc_next = st_rd_data;
                    sat_next = 1'b0;
                    if (j_reg == '0)
                    begin
                        emit     = 1'b1;
                        emit_val = st_rd_data;
                        emit_sat = 1'b0;
                    end
                    else
                    begin
                        j_next     = j_reg - JW'(1);
                        state_next = S_READ;
                    end
                end
                else
                begin
                    mul_load   = 1'b1;
                    state_next = S_SAT;
                end
            end
            S_SAT:
            begin
                acc_next = mul_q;
                sat_next = sat_reg || mul_sat;
                if (j_reg == '0)
                begin
                    emit     = 1'b1;
                    emit_val = mul_q;
                    emit_sat = sat_reg || mul_sat;
                end
                else
                begin
                    j_next     = j_reg - JW'(1);
                    state_next = S_READ;
                end
            end
            S_WAIT:
            begin
                if (!out_stall)
                begin
                    out_valid_next = 1'b0;
                    digit_next     = digit_adv;
                    j_next         = JW'(m_eff - MW'(1));
                    state_next     = last_prod ? S_IDLE : S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // load the output register with a finished product
        if (emit)
        begin
            product_next     = emit_val;
            saturated_next   = emit_sat;
            row_done_next    = last_prod;
            matrix_done_next = last_prod && last_row_reg;
            out_valid_next   = 1'b1;
            state_next       = S_WAIT;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            j_reg         <= '0;
            last_row_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int j = 0; j < MAX_MATRICES; j++)
            begin
                digit_reg[j] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            j_reg         <= j_next;
            last_row_reg  <= last_row_next;
            out_valid_reg <= out_valid_next;
            digit_reg     <= digit_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        acc_reg         <= acc_next;
        sat_reg         <= sat_next;
        product_reg     <= product_next;
        row_done_reg    <= row_done_next;
        matrix_done_reg <= matrix_done_next;
        saturated_reg   <= saturated_next;
    end

    // row store
    rtp_store #(
        .DEPTH (STORE_DEPTH),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (st_wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (value),
        .rd_en   (st_rd_en),
        .rd_addr (st_rd_addr),
        .rd_data (st_rd_data)
    );

    // shared multiply unit
    rtp_mul u_mul (
        .clk  (clk),
        .load (mul_load),
        .a    (st_rd_data),
        .b    (acc_reg),
        .q    (mul_q),
        .sat  (mul_sat)
    );

    assign out_valid   = out_valid_reg;
    assign product     = product_reg;
    assign row_done    = row_done_reg;
    assign matrix_done = matrix_done_reg;
    assign saturated   = saturated_reg;

endmodule

[dv/row_tensor_product_test.sv]
// ----------------------------------------------------------------------------
// row_tensor_product_test
// Self-checking regression for the row-wise tensor product block.
// ----------------------------------------------------------------------------
// Row elements go in through the valid/stall input channel. A predictor keeps
// its own row store, element count and register copy. On each accepted
// element it computes the products that the element releases. A monitor
// compares every product transfer, field by field, with the oldest predicted
// product. Directed rows cover the register extremes, clamped register
// values, saturation in both directions and a register change in the middle
// of a row. Random rows then run under several sender idle and receiver
// stall mixes, followed by a long receiver hold-off.
// ----------------------------------------------------------------------------
module row_tensor_product_test;

    localparam int STORE_DEPTH   = rtp_pkg::DEF_MAX_MATRICES * rtp_pkg::DEF_MAX_COLS;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 1000000;

    localparam logic signed [63:0] Q_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] Q_MIN = 64'shFFFF_FFFF_8000_0000;

    localparam logic [rtp_pkg::DATA_W-1:0] VAL_MAX      = 32'h7FFF_FFFF;
    localparam logic [rtp_pkg::DATA_W-1:0] VAL_MIN      = 32'h8000_0000;
    localparam logic [rtp_pkg::DATA_W-1:0] VAL_ZERO     = 32'h0000_0000;
    localparam logic [rtp_pkg::DATA_W-1:0] VAL_LSB      = 32'h0000_0001;
    localparam logic [rtp_pkg::DATA_W-1:0] VAL_NEG_LSB  = 32'hFFFF_FFFF;
    localparam logic [rtp_pkg::DATA_W-1:0] VAL_ONE      = 32'h0001_0000;
    localparam logic [rtp_pkg::DATA_W-1:0] VAL_NEG_ONE  = 32'hFFFF_0000;
    localparam logic [rtp_pkg::DATA_W-1:0] VAL_HALF     = 32'h0000_8000;

    // one configuration data word
    typedef logic [rtp_pkg::CFG_DATA_W-1:0] cfg_word_t;

    // one predicted product transfer
    typedef struct packed {
        logic [rtp_pkg::DATA_W-1:0] product;
        logic                       row_done;
        logic                       matrix_done;
        logic                       saturated;
    } tensor_term_t;

    logic                              clk;
    logic                              rst_n;
    logic                              cfg_write;
    logic [rtp_pkg::CFG_IDX_W-1:0]     cfg_index;
    logic [rtp_pkg::CFG_DATA_W-1:0]    cfg_data;
    logic                              in_valid;
    logic                              in_stall;
    logic signed [rtp_pkg::DATA_W-1:0] value;
    logic                              final_row;
    logic                              out_valid;
    logic                              out_stall;
    logic signed [rtp_pkg::DATA_W-1:0] product;
    logic                              row_done;
    logic                              matrix_done;
    logic                              saturated;

    // predictor state
    logic [rtp_pkg::MCOUNT_W-1:0]  matrix_count_reg;
    logic [rtp_pkg::COLS_W-1:0]    cols_reg [rtp_pkg::NUM_COL_REGS];
    logic [rtp_pkg::DATA_W-1:0]    row_store [STORE_DEPTH];
    int                            stored_count;
    tensor_term_t                  pending_products [$];

    int failure_count      = 0;
    int cycle_count        = 0;
    int elements_sent      = 0;
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int hold_off_cycles    = 0;

    row_tensor_product DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .value       (value),
        .final_row   (final_row),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .product     (product),
        .row_done    (row_done),
        .matrix_done (matrix_done),
        .saturated   (saturated)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("row_tensor_product regression: fail");
            $finish;
        end
    end

    // matrix count in use, out-of-range values clamped
    function automatic int active_matrices();
        if (matrix_count_reg == 0)
            return 1;
        if (matrix_count_reg > rtp_pkg::DEF_MAX_MATRICES)
            return rtp_pkg::DEF_MAX_MATRICES;
        return int'(matrix_count_reg);
    endfunction

    // column count in use for one matrix, out-of-range values clamped
    function automatic int active_cols(input int mat);
        if (cols_reg[mat] == 0)
            return 1;
        if (cols_reg[mat] > rtp_pkg::DEF_MAX_COLS)
            return rtp_pkg::DEF_MAX_COLS;
        return int'(cols_reg[mat]);
    endfunction

    function automatic int row_length();
        int total;
        int mat;
        total = 0;
        for (mat = 0; mat < active_matrices(); mat++)
            total += active_cols(mat);
        return total;
    endfunction

    // store one element; on the completing element queue every product
    function automatic void compute_row_products(
        input logic [rtp_pkg::DATA_W-1:0] element,
        input logic last_row);
        int mats;
        int total;
        int nprod;
        int k;
        int j;
        int ncols [rtp_pkg::DEF_MAX_MATRICES];
        int base  [rtp_pkg::DEF_MAX_MATRICES];
        int digit [rtp_pkg::DEF_MAX_MATRICES];
        logic signed [63:0] acc;
        logic signed [63:0] factor;
        logic signed [63:0] wide;
        logic sat;
        tensor_term_t term;
        mats  = active_matrices();
        total = 0;
        nprod = 1;
        for (j = 0; j < mats; j++)
        begin
            ncols[j] = active_cols(j);
            base[j]  = total;
            total   += ncols[j];
            nprod   *= ncols[j];
            digit[j] = 0;
        end
        if (stored_count < STORE_DEPTH)
            row_store[stored_count] = element;
        stored_count++;
        if (stored_count < total)
            return;
        stored_count = 0;
        for (k = 0; k < nprod; k++)
        begin
            sat = 1'b0;
            acc = $signed(row_store[base[mats-1] + digit[mats-1]]);
            // fold in factors from the last matrix toward the first
            for (j = mats - 1; j > 0; j--)
            begin
                factor = $signed(row_store[base[j-1] + digit[j-1]]);
                wide   = (factor * acc) >>> rtp_pkg::FRAC_W;
                if (wide > Q_MAX)
                begin
                    acc = Q_MAX;
                    sat = 1'b1;
                end
                else if (wide < Q_MIN)
                begin
                    acc = Q_MIN;
                    sat = 1'b1;
                end
                else
                    acc = wide;
            end
            term.product     = acc[rtp_pkg::DATA_W-1:0];
            term.row_done    = (k == nprod - 1);
            term.matrix_done = (k == nprod - 1) && last_row;
            term.saturated   = sat;
            pending_products.push_back(term);
            // kronecker counter, last matrix fastest
            for (j = mats - 1; j >= 0; j--)
            begin
                digit[j]++;
                if (digit[j] < ncols[j])
                    break;
                digit[j] = 0;
            end
        end
    endfunction

    // register copy, prediction on input transfers, check on output transfers
    always @(posedge clk)
    begin
        tensor_term_t want;
        if (!rst_n)
        begin
            matrix_count_reg = rtp_pkg::MCOUNT_RESET;
            for (int i = 0; i < rtp_pkg::NUM_COL_REGS; i++)
                cols_reg[i] = rtp_pkg::COLS_RESET;
            stored_count = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    rtp_pkg::CFG_MATRIX_COUNT:
                        matrix_count_reg = cfg_data[rtp_pkg::MCOUNT_W-1:0];
                    rtp_pkg::CFG_COLS_FIRST:   cols_reg[0] = cfg_data;
                    rtp_pkg::CFG_COLS_SECOND:  cols_reg[1] = cfg_data;
                    rtp_pkg::CFG_COLS_THIRD:   cols_reg[2] = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                compute_row_products(value, final_row);
            if (out_valid && !out_stall)
            begin
                if (pending_products.size() == 0)
                begin
                    $error("unexpected product transfer: product %0d", product);
                    failure_count++;
                end
                else
                begin
                    want = pending_products.pop_front();
                    if (product !== $signed(want.product))
                    begin
                        $error("product: expected %0d, got %0d",
                               $signed(want.product), product);
                        failure_count++;
                    end
                    if (row_done !== want.row_done)
                    begin
                        $error("row_done: expected %0b, got %0b", want.row_done, row_done);
                        failure_count++;
                    end
                    if (matrix_done !== want.matrix_done)
                    begin
                        $error("matrix_done: expected %0b, got %0b",
                               want.matrix_done, matrix_done);
                        failure_count++;
                    end
                    if (saturated !== want.saturated)
                    begin
                        $error("saturated: expected %0b, got %0b", want.saturated, saturated);
                        failure_count++;
                    end
                end
            end
        end
    end

    // receiver: random stalls, or one long hold-off when asked
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold_off_cycles) @(negedge clk);
                hold_off_cycles = 0;
            end
            else
                out_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    // one element transfer, with random idle cycles ahead of it
    task automatic push_element(input logic [rtp_pkg::DATA_W-1:0] element,
                                input logic last_row);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid  <= 1'b1;
        value     <= element;
        final_row <= last_row;
        do
            @(posedge clk);
        while (in_stall);
        elements_sent++;
    endtask

    task automatic pause_until_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_products.size() != 0)
            @(posedge clk);
    endtask

    // drained and past the pass latency, safe for register writes
    task automatic wait_for_idle();
        pause_until_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(input logic [rtp_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [rtp_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic configure(input logic [rtp_pkg::CFG_DATA_W-1:0] mcount,
                             input logic [rtp_pkg::CFG_DATA_W-1:0] c0,
                             input logic [rtp_pkg::CFG_DATA_W-1:0] c1,
                             input logic [rtp_pkg::CFG_DATA_W-1:0] c2);
        wait_for_idle();
        write_register(rtp_pkg::CFG_MATRIX_COUNT, mcount);
        write_register(rtp_pkg::CFG_COLS_FIRST, c0);
        write_register(rtp_pkg::CFG_COLS_SECOND, c1);
        write_register(rtp_pkg::CFG_COLS_THIRD, c2);
    endtask

    // mix of extremes, small q16.16 values and full-range noise
    function automatic logic [rtp_pkg::DATA_W-1:0] random_value();
        case ($urandom_range(9))
            0: return VAL_MAX;
            1: return VAL_MIN;
            2: return VAL_ZERO;
            3, 4, 5: return $urandom_range(32'h0008_0000) - 32'h0004_0000;
            default: return $urandom;
        endcase
    endfunction

    // mostly small column counts, sometimes the largest or out of range
    function automatic logic [rtp_pkg::CFG_DATA_W-1:0] random_cols();
        int pick;
        pick = $urandom_range(19);
        if (pick < 14)
            return cfg_word_t'($urandom_range(1, 3));
        if (pick < 17)
            return cfg_word_t'(rtp_pkg::DEF_MAX_COLS);
        if (pick == 17)
            return '0;
        return cfg_word_t'($urandom_range(5, 7));
    endfunction

    function automatic logic [rtp_pkg::CFG_DATA_W-1:0] random_matrix_count();
        if ($urandom_range(9) < 8)
            return cfg_word_t'($urandom_range(1, rtp_pkg::DEF_MAX_MATRICES));
        return cfg_word_t'($urandom_range(0, 7));
    endfunction

    // reset registers: one matrix of one column, every element is a product
    task automatic test_reset_settings();
        push_element(VAL_MAX, 1'b0);
        push_element(VAL_MIN, 1'b1);
        push_element(VAL_ZERO, 1'b0);
        push_element(VAL_NEG_LSB, 1'b1);
    endtask

    // three matrices of four columns, saturation both ways, floor rounding
    task automatic test_largest_row();
        configure(3'd3, 3'd4, 3'd4, 3'd4);
        push_element(VAL_MAX, 1'b1);
        push_element(VAL_MIN, 1'b1);
        push_element(VAL_ONE, 1'b1);
        push_element(VAL_NEG_LSB, 1'b1);
        push_element(VAL_MAX, 1'b1);
        push_element(VAL_MIN, 1'b1);
        push_element(VAL_NEG_ONE, 1'b1);
        push_element(VAL_ZERO, 1'b1);
        push_element(VAL_MIN, 1'b1);
        push_element(VAL_MAX, 1'b1);
        push_element(VAL_HALF, 1'b1);
        push_element(VAL_LSB, 1'b1);
    endtask

    // zero and oversize column counts clamp, unused third register ignored
    task automatic test_clamped_registers();
        configure(3'd2, 3'd0, 3'd5, 3'd7);
        push_element(VAL_NEG_ONE, 1'b1);
        push_element(VAL_HALF, 1'b1);
        push_element(VAL_MAX, 1'b1);
        push_element(VAL_NEG_LSB, 1'b1);
        push_element(VAL_ONE, 1'b1);
    endtask

    // row shortened after four elements: the next element completes it
    task automatic test_mid_row_reconfig();
        configure(3'd2, 3'd3, 3'd3, 3'd1);
        push_element(VAL_ONE, 1'b0);
        push_element(VAL_NEG_ONE, 1'b0);
        push_element(VAL_HALF, 1'b0);
        push_element(32'h0002_0000, 1'b0);
        wait_for_idle();
        write_register(rtp_pkg::CFG_COLS_SECOND, 3'd1);
        push_element(VAL_MAX, 1'b1);
    endtask

    // random settings and rows, a few broken rows finished by the next setting
    task automatic test_random_rows(input int idle_pct, input int stall_pct,
                                    input int budget);
        int start;
        int rows;
        int n;
        int i;
        logic last_row;
        logic flag;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        start = elements_sent;
        while (elements_sent - start < budget)
        begin
            configure(random_matrix_count(), random_cols(), random_cols(), random_cols());
            rows = $urandom_range(1, 4);
            repeat (rows)
            begin
                last_row = ($urandom_range(3) == 0);
                n = row_length();
                if ($urandom_range(9) == 0)
                    n = $urandom_range(0, n - 1);
                for (i = 0; i < n; i++)
                begin
                    flag = last_row;
                    if ($urandom_range(9) == 0)
                        flag = !flag;
                    push_element(random_value(), flag);
                end
                if (n < row_length())
                    break;
                if ($urandom_range(7) == 0)
                    pause_until_drained();
            end
        end
    endtask

    // long receiver hold-off fills the block, then rows one drained at a time
    task automatic test_output_hold_off();
        int i;
        logic last_row;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        configure(3'd2, 3'd2, 3'd2, 3'd1);
        hold_off_cycles = 400;
        repeat (6)
        begin
            for (i = 0; i < 4; i++)
                push_element(random_value(), 1'b0);
        end
        while (hold_off_cycles != 0)
            @(negedge clk);
        repeat (3)
        begin
            last_row = 1'($urandom_range(1));
            for (i = 0; i < 4; i++)
                push_element(random_value(), last_row);
            pause_until_drained();
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        value     = '0;
        final_row = 1'b0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        test_reset_settings();
        test_largest_row();
        test_clamped_registers();
        test_mid_row_reconfig();
        test_random_rows(0, 0, 100);
        test_random_rows(69, 0, 100);
        test_random_rows(0, 69, 100);
        test_random_rows(31, 31, 100);
        test_output_hold_off();

        wait_for_idle();
        if (failure_count == 0 && pending_products.size() == 0)
            $display("row_tensor_product regression: pass");
        else
            $display("row_tensor_product regression: fail");
        $finish;
    end

endmodule
